@@ rtl/fezc_pkg.sv @@
package fezc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 16;
   localparam int SQUARE_W   = 31;
   localparam int ENERGY_W   = 43;
   localparam int CROSS_W    = 12;
   localparam int PRODUCT_W  = 54;
   localparam int SUM_W      = ENERGY_W + 1;

   // energy holds at 2^42, crossings at all ones
   localparam logic [SUM_W-1:0]   ENERGY_CAP = SUM_W'(1) << (ENERGY_W - 1);
   localparam logic [CROSS_W-1:0] CROSS_CAP  = '1;

   typedef struct packed {
      logic load_sample;
      logic load_product;
   } cmd_type;

endpackage

@@ rtl/fezc_req_if.sv @@
interface fezc_req_if
   import fezc_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink (input valid, input sample, input frame_end, output ready);
endinterface

@@ rtl/fezc_rsp_if.sv @@
interface fezc_rsp_if
   import fezc_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [ENERGY_W-1:0]   energy;
   logic [CROSS_W-1:0]    crossings;
   logic [PRODUCT_W-1:0]  energy_zero_product;

   modport source (output valid, output energy, output crossings,
                   output energy_zero_product, input ready);
   modport sink (input valid, input energy, input crossings,
                 input energy_zero_product, output ready);
endinterface

@@ rtl/fezc_ctrl.sv @@
module fezc_ctrl
   import fezc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_frame_end,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_MULT,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready        = (state_ff == ST_RUN);
   assign rsp_valid        = (state_ff == ST_SEND);
   assign accept           = req_valid && req_ready;
   assign cmd.load_sample  = accept;
   assign cmd.load_product = (state_ff == ST_MULT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_RUN: begin
            if (accept && req_frame_end) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_MULT;
         ST_MULT:  state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_ready) state_in = ST_RUN;
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/fezc_datapath.sv @@
module fezc_datapath
   import fezc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       frame_end,
   output logic [ENERGY_W-1:0]        energy,
   output logic [CROSS_W-1:0]         crossings,
   output logic [PRODUCT_W-1:0]       product
);

   // square stage
   logic                 sq_valid_ff;
   logic [SQUARE_W-1:0]  square_ff;
   logic                 neg_ff;
   logic                 first_ff;
   logic                 mid_frame_ff;

   // accumulate stage
   logic [ENERGY_W-1:0]  energy_ff, energy_in;
   logic [CROSS_W-1:0]   cross_ff, cross_in;
   logic                 prev_neg_ff;
   logic [PRODUCT_W-1:0] product_ff;

   logic                 neg;
   logic [MAG_W-1:0]     mag;
   logic [2*MAG_W-1:0]   mag_sq;
   logic [ENERGY_W-1:0]  energy_base;
   logic [SUM_W-1:0]     energy_sum;
   logic [ENERGY_W+CROSS_W-1:0] product_full;

   assign neg    = sample[SAMPLE_W-1];
   // most negative sample negates to 0x8000, which reads right as unsigned
   assign mag    = neg ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
   assign mag_sq = mag * mag;

   assign energy_base = first_ff ? '0 : energy_ff;
   assign energy_sum  = {1'b0, energy_base} + SUM_W'(square_ff);
   assign energy_in   = (energy_sum > ENERGY_CAP) ? ENERGY_CAP[ENERGY_W-1:0]
                                                  : energy_sum[ENERGY_W-1:0];

   always_comb begin
      cross_in = first_ff ? '0 : cross_ff;
      if (!first_ff && (neg_ff != prev_neg_ff) && (cross_ff != CROSS_CAP)) begin
         cross_in = cross_ff + 1'b1;
      end
   end

   assign product_full = (ENERGY_W+CROSS_W)'(energy_ff) * (ENERGY_W+CROSS_W)'(cross_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         mid_frame_ff <= 1'b0;
      end else begin
         sq_valid_ff <= cmd.load_sample;
         if (cmd.load_sample) mid_frame_ff <= !frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         square_ff <= mag_sq[SQUARE_W-1:0];
         neg_ff    <= neg;
         first_ff  <= !mid_frame_ff;
      end
      if (sq_valid_ff) begin
         energy_ff   <= energy_in;
         cross_ff    <= cross_in;
         prev_neg_ff <= neg_ff;
      end
      if (cmd.load_product) product_ff <= product_full[PRODUCT_W-1:0];
   end

   assign energy    = energy_ff;
   assign crossings = cross_ff;
   assign product   = product_ff;

endmodule

@@ rtl/frame_energy_zero_crossing_product.sv @@
// frame energy and zero crossing product: signed 16-bit samples stream in on req, grouped
// into frames by frame_end; for each frame the block sums the squared samples (saturating
// at 2^42), counts sign changes between neighboring samples of the frame (zero counts as
// positive, saturating at 4095) and, on the last sample, returns energy, crossing count and
// their product on rsp. within a frame a sample is taken every cycle; the squarer is one
// registered stage and the accumulator the next. after the last sample of a frame, req
// stays not ready while the block steps through accept, accumulate and multiply (43x12
// product register) and then holds the result on rsp until it is transferred; rsp valid
// rises after the drain and multiply states that follow the accept, and req ready returns
// the cycle after the rsp transfer. the sums stay exact for frames of up to 4096 samples
module frame_energy_zero_crossing_product
   import fezc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fezc_req_if.sink   req,
   fezc_rsp_if.source rsp
);

   // command bundle from the controller into the datapath
   cmd_type cmd;

   // sequencer: handshakes and the end-of-frame drain
   fezc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_frame_end (req.frame_end),
      .req_ready     (req.ready),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .cmd           (cmd)
   );

   // squarer, accumulators and final product; result registers feed rsp directly
   fezc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample    (req.sample),
      .frame_end (req.frame_end),
      .energy    (rsp.energy),
      .crossings (rsp.crossings),
      .product   (rsp.energy_zero_product)
   );

endmodule
